>>> hdl/seven_segment_scan_driver_top_macros.svh
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top_macros
// Assertion macros for the seven-segment scan driver.
// Each use names the label, clock, active-low reset and the two sides of the property.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");
// Next-cycle implication.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");
`else
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, command codes and the segment font of the scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [7:0] code_t;
    typedef logic [6:0] seg_t;

    localparam cmd_t CMD_TICK   = 2'd0;
    localparam cmd_t CMD_NUMBER = 2'd1;
    localparam cmd_t CMD_TEXT   = 2'd2;

    localparam code_t BLANK_CODE = 8'hFF;
    localparam int    TEXT_CHARS = 4;
    localparam int    DEC_DIGITS = 4;
    localparam logic [15:0] NUMBER_MAX = 16'd9999;

    localparam int IN_BYTES  = 7;   // 50 payload bits
    localparam int OUT_BYTES = 2;   // 11 payload bits

    // Segment pattern, bit 0 = a ... bit 6 = g.
    function automatic seg_t font(input code_t code);
        seg_t seg;
        case (code)
            8'd0:  seg = 7'h3F;
            8'd1:  seg = 7'h06;
            8'd2:  seg = 7'h5B;
            8'd3:  seg = 7'h4F;
            8'd4:  seg = 7'h66;
            8'd5:  seg = 7'h6D;
            8'd6:  seg = 7'h7D;
            8'd7:  seg = 7'h07;
            8'd8:  seg = 7'h7F;
            8'd9:  seg = 7'h67;
            8'h41: seg = 7'h77; // A
            8'h42: seg = 7'h7C; // B
            8'h43: seg = 7'h39; // C
            8'h44: seg = 7'h5E; // D
            8'h45: seg = 7'h79; // E
            8'h46: seg = 7'h71; // F
            8'h47: seg = 7'h7D; // G
            8'h48: seg = 7'h76; // H
            8'h49: seg = 7'h06; // I
            8'h4C: seg = 7'h38; // L
            8'h4E: seg = 7'h54; // N
            8'h4F: seg = 7'h3F; // O
            8'h50: seg = 7'h73; // P
            8'h52: seg = 7'h50; // R
            8'h53: seg = 7'h6D; // S
            8'h54: seg = 7'h46; // T
            8'h55: seg = 7'h3E; // U
            8'h56: seg = 7'h3E; // V
            8'h59: seg = 7'h6E; // Y
            8'h5A: seg = 7'h5B; // Z
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> hdl/seven_segment_scan_driver_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top
// Multiplexed seven-segment display driver: number/text loads, one digit per tick.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       cmd, number, char_0..char_3
//   m_axis    out  m_axis_tvalid/tready       segments, digit_enable
//
// One item per cycle while no tick is held by a stalled output: a transfer lands in
// the input register and is executed from there, where a tick writes the output register.
// A tick's result is held in the output register and transfers from there.
// Loads never wait; a tick waits only while the output register is full and stalled.
// Reset blanks all digit codes and returns the scan to position 0.
// ----------------------------------------------------------------------------
`include "seven_segment_scan_driver_top_macros.svh"

module seven_segment_scan_driver_top #(
    parameter int NUM_DIGITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], number[17:2], char_0[25:18], char_1[33:26], char_2[41:34],
    // char_3[49:42], zero[55:50]
    input  logic [8*ssd_pkg::IN_BYTES-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // segments[6:0], digit_enable[10:7], zero[15:11]
    output logic [8*ssd_pkg::OUT_BYTES-1:0] m_axis_tdata
);
    import ssd_pkg::*;

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

    // input register
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [15:0]       in_number_reg;
    code_t             in_txt_reg [TEXT_CHARS];

    // state
    code_t             codes_reg  [NUM_DIGITS];
    code_t             codes_next [NUM_DIGITS];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    seg_t              out_seg_reg;
    seg_t              out_seg_next;
    logic [3:0]        out_en_reg;
    logic [3:0]        out_en_next;

    logic              out_free;
    logic              exec;
    logic              in_take;

    // decimal conversion
    logic [13:0]       num_clamp;
    logic [3:0]        dig_th;
    logic [9:0]        rem_th;
    logic [3:0]        dig_hu;
    logic [6:0]        rem_hu;
    logic [3:0]        dig_te;
    logic [3:0]        dig_un;
    logic [3:0]        dec_dig [DEC_DIGITS];
    logic [13:0]       dec_place [DEC_DIGITS];
    logic              txt_alive;
    logic [7:0]        onehot;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign exec          = in_valid_reg && ((in_cmd_reg != CMD_TICK) || out_free);
    assign s_axis_tready = !in_valid_reg || exec;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_en_reg, out_seg_reg};

    // Split the clamped value into decimal digits by compare and subtract.
    always_comb
    begin
        num_clamp = (in_number_reg > NUMBER_MAX) ? NUMBER_MAX[13:0] : in_number_reg[13:0];

        dig_th = 4'd0;
        for (int j = 1; j < 10; j++)
        begin
            if (num_clamp >= 14'(j * 1000))
                dig_th = 4'(j);
        end
        rem_th = 10'(num_clamp - 14'(dig_th) * 14'd1000);

        dig_hu = 4'd0;
        for (int j = 1; j < 10; j++)
        begin
            if (rem_th >= 10'(j * 100))
                dig_hu = 4'(j);
        end
        rem_hu = 7'(rem_th - 10'(dig_hu) * 10'd100);

        dig_te = 4'd0;
        for (int j = 1; j < 10; j++)
        begin
            if (rem_hu >= 7'(j * 10))
                dig_te = 4'(j);
        end
        dig_un = 4'(rem_hu - 7'(dig_te) * 7'd10);

        dec_dig[0]   = dig_un;
        dec_dig[1]   = dig_te;
        dec_dig[2]   = dig_hu;
        dec_dig[3]   = dig_th;
        dec_place[0] = 14'd1;
        dec_place[1] = 14'd10;
        dec_place[2] = 14'd100;
        dec_place[3] = 14'd1000;
    end

    always_comb
    begin
        codes_next     = codes_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_seg_next   = out_seg_reg;
        out_en_next    = out_en_reg;
        txt_alive      = 1'b1;
        onehot         = 8'd1 << pos_reg;

        if (exec)
        begin
            unique case (in_cmd_reg)
                CMD_NUMBER:
                begin
                    for (int i = 0; i < NUM_DIGITS; i++)
                        codes_next[i] = BLANK_CODE;
                    // Right-align; drop leading zeros and digits past position 0.
                    for (int k = 0; k < DEC_DIGITS; k++)
                    begin
                        if (k < NUM_DIGITS && (k == 0 || num_clamp >= dec_place[k]))
                            codes_next[POS_W'(NUM_DIGITS - 1 - k)] = {4'd0, dec_dig[k]};
                    end
                end
                CMD_TEXT:
                begin
                    for (int i = 0; i < NUM_DIGITS; i++)
                        codes_next[i] = BLANK_CODE;
                    // Copy until the first zero code.
                    for (int i = 0; i < TEXT_CHARS; i++)
                    begin
                        if (i < NUM_DIGITS)
                        begin
                            if (in_txt_reg[i] == 8'd0)
                                txt_alive = 1'b0;
                            if (txt_alive)
                                codes_next[POS_W'(i)] = in_txt_reg[i];
                        end
                    end
                end
                CMD_TICK:
                begin
                    out_valid_next = 1'b1;
                    out_seg_next   = font(codes_reg[pos_reg]);
                    out_en_next    = onehot[3:0];
                    pos_next       = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                end
                default:
                begin
                    // reserved command: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            for (int i = 0; i < NUM_DIGITS; i++)
                codes_reg[i] <= BLANK_CODE;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            codes_reg     <= codes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg    <= s_axis_tdata[1:0];
            in_number_reg <= s_axis_tdata[17:2];
            in_txt_reg[0] <= s_axis_tdata[25:18];
            in_txt_reg[1] <= s_axis_tdata[33:26];
            in_txt_reg[2] <= s_axis_tdata[41:34];
            in_txt_reg[3] <= s_axis_tdata[49:42];
        end
        out_seg_reg <= out_seg_next;
        out_en_reg  <= out_en_next;
    end

    `SSD_ASSERT_NEXT(a_tick_yields_result, clk, rst_n,
        exec && in_cmd_reg == CMD_TICK, out_valid_reg)
    `SSD_ASSERT_NEXT(a_load_keeps_position, clk, rst_n,
        !(exec && in_cmd_reg == CMD_TICK), pos_reg == $past(pos_reg))
    `SSD_ASSERT_NOW(a_position_in_range, clk, rst_n,
        1'b1, pos_reg <= POS_LAST)
    `SSD_ASSERT_NOW(a_no_tick_into_stalled_output, clk, rst_n,
        out_valid_reg && !m_axis_tready, !(exec && in_cmd_reg == CMD_TICK))

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the four-digit seven-segment scan driver. Number and
// text loads are mixed with scan ticks; every accepted transfer goes through a
// scoreboard that tracks the digit codes and the scan position. Each tick result
// is checked against the expected segment pattern and digit enable.
// ----------------------------------------------------------------------------
module tb;

    import ssd_pkg::*;

    localparam int   SCAN_DIGITS    = 4;
    localparam int   PHASE_ITEMS    = 300;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   TAIL_CYCLES    = 8;
    localparam cmd_t CMD_UNUSED     = 2'd3;

    typedef struct packed {
        logic [3:0] enable;
        seg_t       segments;
    } lit_digit_t;

    class scan_scoreboard;
        seg_t       glyph [256];
        code_t      digit_code [SCAN_DIGITS];
        int         scan_pos;
        lit_digit_t lit_q [$];
        int         errors;

        function new();
            for (int i = 0; i < 256; i++)
                glyph[i] = 7'h00;
            glyph[0] = 7'h3F; glyph[1] = 7'h06; glyph[2] = 7'h5B; glyph[3] = 7'h4F;
            glyph[4] = 7'h66; glyph[5] = 7'h6D; glyph[6] = 7'h7D; glyph[7] = 7'h07;
            glyph[8] = 7'h7F; glyph[9] = 7'h67;
            glyph[8'h41] = 7'h77; // A
            glyph[8'h42] = 7'h7C; // B
            glyph[8'h43] = 7'h39; // C
            glyph[8'h44] = 7'h5E; // D
            glyph[8'h45] = 7'h79; // E
            glyph[8'h46] = 7'h71; // F
            glyph[8'h47] = 7'h7D; // G
            glyph[8'h48] = 7'h76; // H
            glyph[8'h49] = 7'h06; // I
            glyph[8'h4C] = 7'h38; // L
            glyph[8'h4E] = 7'h54; // N
            glyph[8'h4F] = 7'h3F; // O
            glyph[8'h50] = 7'h73; // P
            glyph[8'h52] = 7'h50; // R
            glyph[8'h53] = 7'h6D; // S
            glyph[8'h54] = 7'h46; // T
            glyph[8'h55] = 7'h3E; // U
            glyph[8'h56] = 7'h3E; // V
            glyph[8'h59] = 7'h6E; // Y
            glyph[8'h5A] = 7'h5B; // Z
            blank_digits();
            scan_pos = 0;
            errors   = 0;
        endfunction

        function void blank_digits();
            for (int i = 0; i < SCAN_DIGITS; i++)
                digit_code[i] = BLANK_CODE;
        endfunction

        function void note_transfer(input cmd_t cmd, input logic [15:0] number,
                                    input logic [31:0] text);
            int unsigned value;
            int unsigned place;
            int          pos;
            code_t       c;
            lit_digit_t  lit;
            case (cmd)
                CMD_NUMBER:
                begin
                    value = (number > NUMBER_MAX) ? NUMBER_MAX : number;
                    place = 1;
                    blank_digits();
                    // units always shown, higher places only once reached
                    for (int k = 0; k < DEC_DIGITS; k++)
                    begin
                        pos = SCAN_DIGITS - 1 - k;
                        if (pos >= 0 && (k == 0 || value >= place))
                            digit_code[pos] = code_t'((value / place) % 10);
                        place = place * 10;
                    end
                end
                CMD_TEXT:
                begin
                    blank_digits();
                    for (int i = 0; i < TEXT_CHARS && i < SCAN_DIGITS; i++)
                    begin
                        c = text[8*i +: 8];
                        if (c == 8'h00)
                            break;
                        digit_code[i] = c;
                    end
                end
                CMD_TICK:
                begin
                    pos          = scan_pos % SCAN_DIGITS;
                    lit.segments = glyph[digit_code[pos]];
                    lit.enable   = 4'(1 << pos);
                    lit_q.push_back(lit);
                    scan_pos     = (pos + 1) % SCAN_DIGITS;
                end
                default: ; // unused command: no state change, no result
            endcase
        endfunction

        task report(input string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(input seg_t segments, input logic [3:0] enable);
            lit_digit_t want;
            if (lit_q.size() == 0)
            begin
                report($sformatf("result with nothing pending: segments=%h enable=%h",
                                 segments, enable));
                return;
            end
            want = lit_q.pop_front();
            if (segments !== want.segments)
                report($sformatf("segments got %h, want %h", segments, want.segments));
            if (enable !== want.enable)
                report($sformatf("digit_enable got %h, want %h", enable, want.enable));
        endtask
    endclass

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [8*IN_BYTES-1:0]       s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [8*OUT_BYTES-1:0]      m_axis_tdata;

    scan_scoreboard sb;
    int             src_idle_pct  = 18;
    int             sink_idle_pct = 84;
    int             quiet_cycles  = 0;
    string          letters       = "ABCDEFGHILNOPRSTUVYZ";

    seven_segment_scan_driver_top #(
        .NUM_DIGITS(SCAN_DIGITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Idle for random single cycles, then drive one item and hold it until the transfer.
    task automatic drive_item(input cmd_t cmd, input logic [15:0] number,
                              input code_t c0, input code_t c1,
                              input code_t c2, input code_t c3);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {6'd0, c3, c2, c1, c0, number, cmd};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_transfer(cmd, number, {c3, c2, c1, c0});
    endtask

    task automatic scan_tick();
        drive_item(CMD_TICK, 16'($urandom), code_t'($urandom), code_t'($urandom),
                   code_t'($urandom), code_t'($urandom));
    endtask

    task automatic load_number(input logic [15:0] number);
        drive_item(CMD_NUMBER, number, code_t'($urandom), code_t'($urandom),
                   code_t'($urandom), code_t'($urandom));
    endtask

    task automatic load_text(input code_t c0, input code_t c1,
                             input code_t c2, input code_t c3);
        drive_item(CMD_TEXT, 16'($urandom), c0, c1, c2, c3);
    endtask

    function automatic code_t pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 8'h00;
        else if (r < 45)
            return code_t'(letters[$urandom_range(letters.len() - 1)]);
        else if (r < 65)
            return code_t'($urandom_range(9));
        else if (r < 72)
            return BLANK_CODE;
        return code_t'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_number();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 16'($urandom_range(65535));
        else if (r < 55)
            return 16'($urandom_range(9999));
        else if (r < 75)
            return 16'($urandom_range(99));
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd9;
            2: return 16'd10;
            3: return 16'd99;
            4: return 16'd100;
            5: return 16'd999;
            6: return 16'd1000;
            7: return 16'd9999;
            8: return 16'd10000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Result side: check every transfer, then pick tready for the next cycle.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[6:0], m_axis_tdata[10:7]);
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int counted;
        int r;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blank digits out of reset
        scan_tick();
        scan_tick();
        // clamp above 9999
        load_number(16'hFFFF);
        scan_tick();
        scan_tick();
        // zero: only the units digit lit
        load_number(16'd0);
        repeat (4) scan_tick();
        load_number(16'd1000);
        scan_tick();
        load_number(16'd10);
        scan_tick();
        // zero ends the text early
        load_text(8'h48, 8'h49, 8'h00, 8'h58);
        scan_tick();
        scan_tick();
        drive_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        scan_tick();
        // empty text blanks everything
        load_text(8'h00, 8'h41, 8'h42, 8'h43);
        scan_tick();
        // blank and unmapped codes stay dark
        load_text(8'h41, BLANK_CODE, 8'h80, 8'h5A);
        scan_tick();
        scan_tick();
        load_number(16'd100);
        load_number(16'd9);
        scan_tick();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 18; sink_idle_pct = 84; end
                1: begin src_idle_pct = 84; sink_idle_pct = 18; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 4)
                    drive_item(CMD_UNUSED, 16'($urandom), code_t'($urandom),
                               code_t'($urandom), code_t'($urandom), code_t'($urandom));
                else
                begin
                    if (r < 62)
                        scan_tick();
                    else if (r < 81)
                        load_number(pick_number());
                    else
                        load_text(pick_char(), pick_char(), pick_char(), pick_char());
                    counted++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.lit_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.lit_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
